/* sv/pfbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_pkg
// Types and constants shared by the packet framer core and its sequencer.
// ----------------------------------------------------------------------------
package pfbs_pkg;

  localparam logic [7:0] START_MARKER_RST = 8'h03;
  localparam logic [7:0] END_MARKER_RST   = 8'h02;

  localparam logic CFG_START_MARKER = 1'b0;
  localparam logic CFG_END_MARKER   = 1'b1;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef enum logic [10:0] {
    SEQ_IDLE     = 11'b000_0000_0001,
    SEQ_START    = 11'b000_0000_0010,
    SEQ_ZERO     = 11'b000_0000_0100,
    SEQ_NUM_HI   = 11'b000_0000_1000,
    SEQ_NUM_LO   = 11'b000_0001_0000,
    SEQ_LEN_HI   = 11'b000_0010_0000,
    SEQ_LEN_LO   = 11'b000_0100_0000,
    SEQ_PAYLOAD  = 11'b000_1000_0000,
    SEQ_END      = 11'b001_0000_0000,
    SEQ_END_ZERO = 11'b010_0000_0000,
    SEQ_PAD      = 11'b100_0000_0000
  } seq_state_t;

  typedef struct packed {
    logic        header;
    logic        close;
    logic [15:0] packet_number;
    logic [15:0] data_length;
    logic [7:0]  payload_byte;
  } item_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } emit_t;

endpackage

/* sv/pfbs_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pfbs_seq
// Holds one accepted word and walks its output bytes, one per advance.
// ----------------------------------------------------------------------------
module pfbs_seq
  import pfbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  item_t      item_in,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  input  logic       adv,
  output emit_t      emit
);

  seq_state_t state, state_next;
  item_t      item;
  logic       dup, dup_next;
  logic [1:0] word_phase, phase_after;
  logic [7:0] cur;
  logic       content, need_dup, fire;

  always_comb begin
    cur     = 8'h00;
    content = 1'b0;
    unique case (state)
      SEQ_START:   cur = start_marker;
      SEQ_NUM_HI:  begin cur = item.packet_number[15:8]; content = 1'b1; end
      SEQ_NUM_LO:  begin cur = item.packet_number[7:0];  content = 1'b1; end
      SEQ_LEN_HI:  begin cur = item.data_length[15:8];   content = 1'b1; end
      SEQ_LEN_LO:  begin cur = item.data_length[7:0];    content = 1'b1; end
      SEQ_PAYLOAD: begin cur = item.payload_byte;        content = 1'b1; end
      SEQ_END:     cur = end_marker;
      default:     cur = 8'h00;
    endcase
  end

  assign need_dup    = content && !dup && (cur == start_marker || cur == end_marker);
  assign phase_after = (state == SEQ_START) ? 2'd1 : word_phase + 2'd1;

  always_comb begin
    dup_next   = 1'b0;
    state_next = state;
    if (need_dup) begin
      dup_next = 1'b1;
    end else begin
      unique case (state) inside
        SEQ_START:    state_next = SEQ_ZERO;
        SEQ_ZERO:     state_next = SEQ_NUM_HI;
        SEQ_NUM_HI:   state_next = SEQ_NUM_LO;
        SEQ_NUM_LO:   state_next = SEQ_LEN_HI;
        SEQ_LEN_HI:   state_next = SEQ_LEN_LO;
        SEQ_LEN_LO,
        SEQ_PAYLOAD:  state_next = item.close ? SEQ_END : SEQ_IDLE;
        SEQ_END:      state_next = SEQ_END_ZERO;
        SEQ_END_ZERO,
        SEQ_PAD:      state_next = (phase_after == 2'd0) ? SEQ_IDLE : SEQ_PAD;
        default:      state_next = SEQ_IDLE;
      endcase
    end
  end

  assign emit.valid      = (state != SEQ_IDLE);
  assign emit.out_byte   = cur;
  assign emit.run_last   = (state_next == SEQ_IDLE);
  assign emit.frame_done = (state == SEQ_END_ZERO || state == SEQ_PAD) &&
                           (word_phase == 2'd3);

  assign fire = emit.valid && adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= SEQ_IDLE;
      dup        <= 1'b0;
      word_phase <= 2'd0;
    end else begin
      if (fire) begin
        word_phase <= phase_after;
      end
      if (load) begin
        state <= item_in.header ? SEQ_START : SEQ_PAYLOAD;
        dup   <= 1'b0;
      end else if (fire) begin
        state <= state_next;
        dup   <= dup_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item <= item_in;
    end
  end

endmodule

/* sv/packet_framer_byte_stuffing_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_framer_byte_stuffing_core
// Frames header/payload words into an escaped byte stream.
// ----------------------------------------------------------------------------
// Slave side takes header words (tuser = 0: number and length) and payload
// words (tuser = 1: one byte). Master side gives one framed byte per word;
// tlast marks the last byte caused by an input word, tuser marks the last
// byte of a frame. A header gives start marker, zero, number and length
// (high bytes first); content bytes equal to either marker are doubled. When
// the length count runs out the end marker, a zero and zero padding to a
// four-byte boundary follow. A header mid-packet restarts framing; payload
// words outside a packet are dropped.
// Each word yields one byte per advance (1 to 7 for payload, 6 to 12 for
// a header); the next word is accepted in the cycle the last byte is
// loaded into the output register, so plain payload runs at one word per
// cycle while m_tready is high. The output register holds its byte while
// m_tready is low, and the slave side then waits. Reset clears the packet
// state and loads the markers with 3 (start) and 2 (end); cfg writes set
// them.
// ----------------------------------------------------------------------------
module packet_framer_byte_stuffing_core
  import pfbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // packet_number, data_length, payload_byte
  input  logic        s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast,
  output logic        m_tuser,   // frame_done
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data
);

  logic [7:0]  start_marker, end_marker;
  logic        packet_open;
  logic [15:0] bytes_remaining;
  logic        accept, adv, start_seq;
  item_t       item_in;
  emit_t       emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RST;
      end_marker   <= END_MARKER_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_START_MARKER: start_marker <= cfg_data;
        CFG_END_MARKER:   end_marker   <= cfg_data;
        default:          ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = !emit.valid || (emit.run_last && adv);
  assign accept   = s_tvalid && s_tready;

  assign item_in.header        = (s_tuser == KIND_HEADER);
  assign item_in.packet_number = s_tdata[15:0];
  assign item_in.data_length   = s_tdata[31:16];
  assign item_in.payload_byte  = s_tdata[39:32];
  assign item_in.close         = (s_tuser == KIND_HEADER) ? (s_tdata[31:16] == 16'd0)
                                                          : (bytes_remaining == 16'd1);

  assign start_seq = accept && (s_tuser == KIND_HEADER || packet_open);

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open     <= 1'b0;
      bytes_remaining <= 16'd0;
    end else if (start_seq) begin
      if (s_tuser == KIND_HEADER) begin
        packet_open     <= !item_in.close;
        bytes_remaining <= item_in.close ? 16'd0 : s_tdata[31:16];
      end else begin
        packet_open     <= !item_in.close;
        bytes_remaining <= bytes_remaining - 16'd1;
      end
    end
  end

  pfbs_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .load         (start_seq),
    .item_in      (item_in),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .adv          (adv),
    .emit         (emit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= emit.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && emit.valid) begin
      m_tdata <= emit.out_byte;
      m_tlast <= emit.run_last;
      m_tuser <= emit.frame_done;
    end
  end

endmodule

/* sim/packet_framer_byte_stuffing_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_framer_byte_stuffing_core_test
// Self-checking bench for the byte-stuffing packet framer.
// ----------------------------------------------------------------------------
// Drives header and payload words into the framer and predicts the framed,
// escaped byte stream: start marker, zero, number and length, doubled marker
// bytes, end marker, zero and padding to four bytes. Every output word is
// checked against the prediction. Runs a directed set, then random packets
// (some cut short, some stray payload) under several marker settings and
// with random gaps and backpressure on both sides.
// ----------------------------------------------------------------------------
module packet_framer_byte_stuffing_core_test;
  import pfbs_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int DROP_SETTLE = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int WORDS_PER_PHASE = 40;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_done;
  } frame_byte_t;

  class framer_scoreboard;
    logic [7:0]  start_mk;
    logic [7:0]  end_mk;
    bit          frame_open;
    logic [15:0] remaining;
    logic [1:0]  byte_phase;
    frame_byte_t staged[$];
    frame_byte_t pending[$];
    int          errors;

    function new();
      start_mk   = START_MARKER_RST;
      end_mk     = END_MARKER_RST;
      frame_open = 1'b0;
      remaining  = '0;
      byte_phase = '0;
      errors     = 0;
    endfunction

    function void put_byte(logic [7:0] b, logic done);
      frame_byte_t fb;
      fb.out_byte   = b;
      fb.run_last   = 1'b0;
      fb.frame_done = done;
      staged.push_back(fb);
      byte_phase = byte_phase + 2'd1;
    endfunction

    function void put_content(logic [7:0] b);
      put_byte(b, 1'b0);
      if (b == start_mk || b == end_mk) put_byte(b, 1'b0);
    endfunction

    function void close_frame();
      put_byte(end_mk, 1'b0);
      put_byte(8'h00, byte_phase == 2'd3);
      while (byte_phase != 2'd0) put_byte(8'h00, byte_phase == 2'd3);
      frame_open = 1'b0;
      remaining  = '0;
    endfunction

    // Notes an accepted word; returns the number of bytes it will produce.
    function int note_word(logic kind, logic [15:0] num, logic [15:0] len,
                           logic [7:0] pb);
      int n;
      staged.delete();
      if (kind == KIND_HEADER) begin
        byte_phase = '0;
        put_byte(start_mk, 1'b0);
        put_byte(8'h00, 1'b0);
        put_content(num[15:8]);
        put_content(num[7:0]);
        put_content(len[15:8]);
        put_content(len[7:0]);
        frame_open = 1'b1;
        remaining  = len;
        if (len == 16'd0) close_frame();
      end else if (frame_open) begin
        put_content(pb);
        remaining = remaining - 16'd1;
        if (remaining == 16'd0) close_frame();
      end
      n = staged.size();
      if (n != 0) staged[n-1].run_last = 1'b1;
      foreach (staged[i]) pending.push_back(staged[i]);
      return n;
    endfunction

    function void check_byte(logic [7:0] b, logic last, logic done);
      frame_byte_t exp_b;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte %h last %b done %b",
                 $time, b, last, done);
        errors++;
        return;
      end
      exp_b = pending.pop_front();
      if (b !== exp_b.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, exp_b.out_byte, b);
        errors++;
      end
      if (last !== exp_b.run_last) begin
        $display("%0t: tlast expected %b actual %b", $time, exp_b.run_last, last);
        errors++;
      end
      if (done !== exp_b.frame_done) begin
        $display("%0t: tuser expected %b actual %b", $time, exp_b.frame_done, done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // packet_number, data_length, payload_byte
  logic        s_tuser;   // kind
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte
  logic        m_tlast;
  logic        m_tuser;   // frame_done
  logic        cfg_we;
  logic        cfg_addr;
  logic [7:0]  cfg_data;

  framer_scoreboard book;
  int send_idle_pct;
  int stall_pct;
  bit hold_req;
  int words_sent;
  int quiet_cycles;

  packet_framer_byte_stuffing_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_byte(m_tdata, m_tlast, m_tuser);
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("packet_framer_byte_stuffing_core test failed");
      $finish;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return book.start_mk;
      1: return book.end_mk;
      2: return 8'h00;
      3: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic kind, input logic [15:0] num,
                           input logic [15:0] len, input logic [7:0] pb);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pb, len, num};
    s_tuser  <= kind;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (book.note_word(kind, num, len, pb) != 0) words_sent++;
  endtask

  task automatic send_header(input logic [15:0] num, input logic [15:0] len);
    send_word(KIND_HEADER, num, len, 8'($urandom));
  endtask

  task automatic send_payload(input logic [7:0] pb);
    send_word(KIND_PAYLOAD, 16'($urandom), 16'($urandom), pb);
  endtask

  task automatic send_packet();
    logic [15:0] num;
    logic [15:0] len;
    int          n;
    int unsigned r;
    if ($urandom_range(9) == 0) send_payload(pick_byte());
    num = {pick_byte(), pick_byte()};
    r = $urandom_range(19);
    if (r < 14) begin
      len = 16'($urandom_range(0, 6));
    end else if (r < 18) begin
      len = 16'($urandom_range(7, 24));
    end else begin
      len = {pick_byte(), pick_byte()};
    end
    n = len;
    if (len > 24) begin
      n = $urandom_range(0, 8);
    end else if (len != 0 && $urandom_range(7) == 0) begin
      n = $urandom_range(0, len - 1);
    end
    send_header(num, len);
    repeat (n) send_payload(pick_byte());
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (DROP_SETTLE) @(posedge clk);
  endtask

  task automatic set_markers(input logic [7:0] smk, input logic [7:0] emk);
    cfg_we   <= 1'b1;
    cfg_addr <= CFG_START_MARKER;
    cfg_data <= smk;
    @(posedge clk);
    book.start_mk = smk;
    cfg_addr <= CFG_END_MARKER;
    cfg_data <= emk;
    @(posedge clk);
    book.end_mk = emk;
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [7:0] smk_tab[5];
    logic [7:0] emk_tab[5];
    book = new();
    smk_tab = '{8'h03, 8'h00, 8'hFF, 8'hFF, 8'h7E};
    emk_tab = '{8'h02, 8'h00, 8'hFF, 8'h00, 8'h7D};
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = KIND_HEADER;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_START_MARKER;
    cfg_data     = '0;
    send_idle_pct = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    words_sent   = 0;
    quiet_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: drops, markers in content, zero length, restarts, padding
    send_payload(8'hAB);
    send_header(16'h0302, 16'h0000);
    send_header(16'hFFFF, 16'h0001);
    send_payload(8'h03);
    send_header(16'h0000, 16'h0203);
    send_payload(8'h02);
    send_payload(8'hFF);
    send_header(16'h1234, 16'hFFFF);
    send_payload(8'h00);
    send_header(16'h0203, 16'h0002);
    send_payload(8'h02);
    send_payload(8'h03);
    send_header(16'h5AA5, 16'h0003);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'h80);
    send_payload(8'h03);
    send_header(16'h0202, 16'h0303);
    send_header(16'h8001, 16'h0004);
    repeat (4) send_payload(8'h7F);
    wait_idle();

    for (int p = 0; p < 5; p++) begin
      if (p != 0) set_markers(smk_tab[p], emk_tab[p]);
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 63; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 63; end
        default: begin send_idle_pct = 36; stall_pct = 36; end
      endcase
      if (p == 0) hold_req = 1'b1;
      words_sent = 0;
      while (words_sent < WORDS_PER_PHASE) send_packet();
      wait_idle();
    end

    repeat (30) @(posedge clk);
    if (book.errors == 0) begin
      $display("packet_framer_byte_stuffing_core test passed");
    end else begin
      $display("packet_framer_byte_stuffing_core test failed");
    end
    $finish;
  end

endmodule
